// ===== rtl/ucr_pkg.sv =====
// Shared types, constants and helpers for the ultrasonic echo ranger.
// No dependencies; every other file but ucr_tick_if imports this package.
package ucr_pkg;

  // Fixed-point fraction of the reported distance.
  localparam int FRACTION_BITS = 4;

  localparam int TW     = 16;  // tick counters and echo width
  localparam int DIST_W = 14;  // distance_q4 field
  localparam int CFG_DW = 16;  // widest configuration register
  localparam int CFG_IW = 3;   // register index

  localparam logic [TW-1:0] TICKS_PER_CM    = 16'd58;
  localparam logic [TW-1:0] TRIG_LOW_TICKS  = 16'd3;
  localparam logic [TW-1:0] TRIG_HIGH_TICKS = 16'd10;
  localparam logic [TW-1:0] WIDTH_MAX       = 16'hFFFF;
  localparam logic [1:0]    ATTEMPTS        = 2'd3;
  localparam logic [DIST_W-1:0] Q_MAX       = 14'h3FFF;

  // Running quotient of (width << FRACTION_BITS) / 58, advanced one tick at a time.
  localparam int STEP   = 1 << FRACTION_BITS;
  localparam int STEP_Q = STEP / 58;
  localparam int STEP_R = STEP % 58;
  localparam int QW_RAW = $clog2(((65535 << FRACTION_BITS) / 58) + 1);
  localparam int QW     = (QW_RAW > DIST_W) ? QW_RAW : DIST_W;
  localparam int RW     = 6;  // remainder, always below 58

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_MEDIAN_MODE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_CM      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MAX_CM      = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ECHO_TMO    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_GAP         = 3'd4;

  typedef struct packed {
    logic          median_mode;
    logic [TW-1:0] lo_ticks;      // min_cm * 58
    logic [TW-1:0] hi_ticks;      // max_cm * 58
    logic [TW-1:0] echo_timeout;
    logic [TW-1:0] gap;
  } ucr_cfg_t;

  typedef struct packed {
    logic              trig;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_q4;
  } ucr_res_t;

  function automatic logic [DIST_W-1:0] med3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    logic [DIST_W-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

// ===== rtl/ucr_tick_if.sv =====
// Input channel of the echo ranger: one item per microsecond tick.
// Depends on nothing.
interface ucr_tick_if;
  logic valid;
  logic ready;
  logic op;
  logic echo;

  modport source (output valid, output op, output echo, input ready);
  modport sink   (input valid, input op, input echo, output ready);
endinterface

// ===== rtl/ucr_result_if.sv =====
// Result channel of the echo ranger: one item for every accepted tick.
// Depends on ucr_pkg for the distance width.
interface ucr_result_if;
  import ucr_pkg::*;
  logic              valid;
  logic              ready;
  logic              trig;
  logic              busy_res;
  logic              done_res;
  logic [1:0]        status;
  logic [DIST_W-1:0] distance_q4;

  modport source (output valid, output trig, output busy_res, output done_res,
                  output status, output distance_q4, input ready);
  modport sink   (input valid, input trig, input busy_res, input done_res,
                  input status, input distance_q4, output ready);
endinterface

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config registers, sequencer and
// result queue. Depends on ucr_pkg, ucr_tick_if and ucr_result_if.
//
// Feed one tick item per microsecond; op=1 starts a measurement when idle.
// Every accepted tick yields exactly one result item, which can be taken from
// the cycle after the tick was accepted. The block takes one tick per clock:
// all work for a tick is a single pass through the sequencer between its
// state registers and a two-entry result queue, and tick ready drops only
// while two results are waiting to be taken. The distance divide by 58 is
// carried as a running quotient and remainder updated each echo-high tick,
// and the range limits are converted to ticks when min_cm and max_cm are
// written. Write configuration only while no measurement is running. There
// is no clearing pass after reset.
module ultrasonic_echo_ranger
  import ucr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CFG_IW-1:0] wr_index,
  input  logic [CFG_DW-1:0] wr_data,
  ucr_tick_if.sink          tick,
  ucr_result_if.source      result
);

  ucr_cfg_t cfg;
  ucr_res_t seq_res;
  ucr_res_t buf_res;
  logic     buf_ready;
  logic     tick_acc;

  // accept a tick whenever the queue has room
  assign tick.ready = buf_ready;
  assign tick_acc   = tick.valid && buf_ready;

  ucr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  ucr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .acc  (tick_acc),
    .op   (tick.op),
    .echo (tick.echo),
    .res  (seq_res)
  );

  ucr_out_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (tick_acc),
    .wr_data  (seq_res),
    .wr_ready (buf_ready),
    .rd_valid (result.valid),
    .rd_ready (result.ready),
    .rd_data  (buf_res)
  );

  // unpack the queued item onto the result channel
  assign result.trig        = buf_res.trig;
  assign result.busy_res    = buf_res.busy_res;
  assign result.done_res    = buf_res.done_res;
  assign result.status      = buf_res.status;
  assign result.distance_q4 = buf_res.distance_q4;

endmodule

// ===== rtl/ucr_cfg_regs.sv =====
// Configuration registers of the echo ranger, with the range limits
// converted to ticks at write time. Depends on ucr_pkg.
module ucr_cfg_regs
  import ucr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CFG_IW-1:0] wr_index,
  input  logic [CFG_DW-1:0] wr_data,
  output ucr_cfg_t          cfg
);

  logic [TW-1:0] cm_ticks;

  // 58 * cm fits in 16 bits for any 10-bit cm
  assign cm_ticks = 16'({6'd0, wr_data[9:0]} * TICKS_PER_CM);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.median_mode  <= 1'b0;
      cfg.lo_ticks     <= 16'd116;
      cfg.hi_ticks     <= 16'd23200;
      cfg.echo_timeout <= 16'd30000;
      cfg.gap          <= 16'd15000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MEDIAN_MODE: cfg.median_mode  <= wr_data[0];
        REG_MIN_CM:      cfg.lo_ticks     <= cm_ticks;
        REG_MAX_CM:      cfg.hi_ticks     <= cm_ticks;
        REG_ECHO_TMO:    cfg.echo_timeout <= wr_data;
        REG_GAP:         cfg.gap          <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ucr_seq.sv =====
// Measurement sequencer: trigger pulse, echo edge waits, width-to-distance
// conversion and median of three. Depends on ucr_pkg.
module ucr_seq
  import ucr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ucr_cfg_t cfg,
  input  logic     acc,
  input  logic     op,
  input  logic     echo,
  output ucr_res_t res
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LOW  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_RISE = 3'd3;
  localparam logic [2:0] PH_FALL = 3'd4;
  localparam logic [2:0] PH_GAP  = 3'd5;

  logic [2:0]        phase, phase_next;
  logic [TW-1:0]     tick_count, tick_count_next;
  logic [TW-1:0]     echo_width, echo_width_next;
  logic [QW-1:0]     q_acc, q_acc_next;
  logic [RW-1:0]     r_acc, r_acc_next;
  logic [1:0]        attempt_index, attempt_next;
  logic [1:0]        success_count, success_next;
  logic [DIST_W-1:0] store [3];

  logic              start;
  logic [2:0]        ph_cur;
  logic [TW-1:0]     tc_cur;
  logic [1:0]        ai_cur, sc_cur;

  logic              fin, gap_end, store_we;
  logic [1:0]        fin_st;
  logic [DIST_W-1:0] fin_q, q_sat;
  logic [DIST_W-1:0] eff0, eff1, eff2;
  logic [RW:0]       r_sum;

  assign start  = (phase == PH_IDLE) && op;
  assign ph_cur = start ? PH_LOW : phase;
  assign tc_cur = start ? '0 : tick_count;
  assign ai_cur = start ? '0 : attempt_index;
  assign sc_cur = start ? '0 : success_count;

  assign q_sat = (q_acc > QW'(Q_MAX)) ? Q_MAX : q_acc[DIST_W-1:0];
  assign r_sum = {1'b0, r_acc} + (RW+1)'(STEP_R);

  always_comb begin
    phase_next      = ph_cur;
    tick_count_next = tc_cur;
    echo_width_next = echo_width;
    q_acc_next      = q_acc;
    r_acc_next      = r_acc;
    attempt_next    = ai_cur;
    success_next    = sc_cur;
    fin      = 1'b0;
    fin_st   = ST_OK;
    fin_q    = '0;
    gap_end  = 1'b0;
    store_we = 1'b0;
    eff0     = store[0];
    eff1     = store[1];
    eff2     = store[2];
    res      = '0;

    unique case (ph_cur)
      PH_IDLE: ;
      PH_LOW: begin
        tick_count_next = 16'(tc_cur + 16'd1);
        if (tick_count_next >= TRIG_LOW_TICKS) begin
          phase_next      = PH_HIGH;
          tick_count_next = '0;
        end
      end
      PH_HIGH: begin
        res.trig        = 1'b1;
        tick_count_next = 16'(tc_cur + 16'd1);
        if (tick_count_next >= TRIG_HIGH_TICKS) begin
          phase_next      = PH_RISE;
          tick_count_next = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          // rise tick counts as width 1
          phase_next      = PH_FALL;
          tick_count_next = '0;
          echo_width_next = 16'd1;
          q_acc_next      = QW'(STEP_Q);
          r_acc_next      = RW'(STEP_R);
        end else if (tc_cur >= cfg.echo_timeout) begin
          fin    = 1'b1;
          fin_st = ST_TIMEOUT;
        end else begin
          tick_count_next = 16'(tc_cur + 16'd1);
        end
      end
      PH_FALL: begin
        if (!echo) begin
          fin = 1'b1;
          if (echo_width < cfg.lo_ticks || echo_width > cfg.hi_ticks) begin
            fin_st = ST_RANGE;
          end else begin
            fin_st = ST_OK;
            fin_q  = q_sat;
          end
        end else if (tc_cur >= cfg.echo_timeout) begin
          fin    = 1'b1;
          fin_st = ST_TIMEOUT;
        end else begin
          tick_count_next = 16'(tc_cur + 16'd1);
          if (echo_width != WIDTH_MAX) begin
            // advance the quotient by one tick's worth
            echo_width_next = 16'(echo_width + 16'd1);
            if (r_sum >= (RW+1)'(58)) begin
              r_acc_next = RW'(r_sum - (RW+1)'(58));
              q_acc_next = QW'(q_acc + QW'(STEP_Q + 1));
            end else begin
              r_acc_next = r_sum[RW-1:0];
              q_acc_next = QW'(q_acc + QW'(STEP_Q));
            end
          end
        end
      end
      PH_GAP: begin
        tick_count_next = 16'(tc_cur + 16'd1);
        if (tick_count_next >= cfg.gap) gap_end = 1'b1;
      end
      default: phase_next = PH_IDLE;
    endcase

    if (fin) begin
      if (!cfg.median_mode) begin
        phase_next      = PH_IDLE;
        res.done_res    = 1'b1;
        res.status      = fin_st;
        res.distance_q4 = (fin_st == ST_OK) ? fin_q : '0;
      end else begin
        if (fin_st == ST_OK && sc_cur < ATTEMPTS) begin
          store_we     = 1'b1;
          success_next = 2'(sc_cur + 2'd1);
        end
        if (ai_cur < ATTEMPTS) attempt_next = 2'(ai_cur + 2'd1);
        if (cfg.gap == '0) begin
          gap_end = 1'b1;
        end else begin
          phase_next      = PH_GAP;
          tick_count_next = '0;
        end
      end
    end

    // forward a sample written this tick
    if (store_we && sc_cur == 2'd0) eff0 = fin_q;
    if (store_we && sc_cur == 2'd1) eff1 = fin_q;
    if (store_we && sc_cur == 2'd2) eff2 = fin_q;

    if (gap_end) begin
      if (attempt_next >= ATTEMPTS) begin
        phase_next   = PH_IDLE;
        res.done_res = 1'b1;
        if (success_next == 2'd0) begin
          res.status = ST_TIMEOUT;
        end else if (success_next == ATTEMPTS) begin
          res.status      = ST_OK;
          res.distance_q4 = med3(eff0, eff1, eff2);
        end else begin
          res.status      = ST_OK;
          res.distance_q4 = eff0;
        end
      end else begin
        phase_next      = PH_LOW;
        tick_count_next = '0;
      end
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      echo_width    <= '0;
      q_acc         <= '0;
      r_acc         <= '0;
      attempt_index <= '0;
      success_count <= '0;
    end else if (acc) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      echo_width    <= echo_width_next;
      q_acc         <= q_acc_next;
      r_acc         <= r_acc_next;
      attempt_index <= attempt_next;
      success_count <= success_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && store_we) store[sc_cur] <= fin_q;
  end

endmodule

// ===== rtl/ucr_out_buf.sv =====
// Two-entry result queue that parts the tick side from the result side.
// Depends on ucr_pkg for the result type.
module ucr_out_buf
  import ucr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  input  ucr_res_t wr_data,
  output logic     wr_ready,
  output logic     rd_valid,
  input  logic     rd_ready,
  output ucr_res_t rd_data
);

  ucr_res_t   mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= 2'(count + 2'd1);
        2'b01:   count <= 2'(count - 2'd1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== sim/ultrasonic_echo_ranger_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ultrasonic_echo_ranger: feeds microsecond ticks with echo
// waveforms and checks every result item against a cycle-free model of the ranging sequence.
// Depends on ucr_pkg, ucr_tick_if, ucr_result_if and the ranger RTL.
module ultrasonic_echo_ranger_test;
  import ucr_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TAIL_CYCLES = 8;
  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LOW, PH_HIGH, PH_RISE, PH_FALL, PH_GAP
  } ranger_phase_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              wr_en;
  logic [CFG_IW-1:0] wr_index;
  logic [CFG_DW-1:0] wr_data;

  ucr_tick_if   tick ();
  ucr_result_if result ();

  ultrasonic_echo_ranger dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .tick     (tick),
    .result   (result)
  );

  always #10 clk = ~clk;

  // Mirror of the configuration registers, at their reset values.
  logic          cfg_median  = 1'b0;
  logic [9:0]    cfg_min_cm  = 10'd2;
  logic [9:0]    cfg_max_cm  = 10'd400;
  logic [TW-1:0] cfg_timeout = 16'd30000;
  logic [TW-1:0] cfg_gap     = 16'd15000;

  // Model state of the ranging sequence.
  ranger_phase_t     ph          = PH_IDLE;
  logic [TW-1:0]     phase_ticks = '0;
  logic [TW-1:0]     pulse_width = '0;
  logic [1:0]        attempt_no  = '0;
  logic [1:0]        good_count  = '0;
  logic [DIST_W-1:0] good_dist [3];
  ucr_res_t          tick_out;

  ucr_res_t    tick_results_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles_run = 0;
  bit          bursts_on  = 1'b1;

  // ---------------------------------------------------------------------------
  // Model of one tick
  // ---------------------------------------------------------------------------

  function automatic logic [DIST_W-1:0] mid_of_three(input logic [DIST_W-1:0] a,
                                                     input logic [DIST_W-1:0] b,
                                                     input logic [DIST_W-1:0] c);
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    return c;
  endfunction

  // Mark this tick's result as finished; distance only rides along with ok.
  function automatic void post_result(input logic [1:0] st, input logic [DIST_W-1:0] q);
    tick_out.done_res    = 1'b1;
    tick_out.status      = st;
    tick_out.distance_q4 = (st == ST_OK) ? q : '0;
  endfunction

  // End of the pause after an attempt: vote after the third, else trigger again.
  function automatic void close_gap();
    if (attempt_no >= ATTEMPTS) begin
      ph = PH_IDLE;
      if (good_count == 0)
        post_result(ST_TIMEOUT, '0);
      else if (good_count >= 3)
        post_result(ST_OK, mid_of_three(good_dist[0], good_dist[1], good_dist[2]));
      else
        post_result(ST_OK, good_dist[0]);
    end else begin
      ph = PH_LOW;
      phase_ticks = '0;
    end
  endfunction

  function automatic void end_attempt(input logic [1:0] st, input logic [DIST_W-1:0] q);
    if (!cfg_median) begin
      ph = PH_IDLE;
      post_result(st, q);
      return;
    end
    // In median mode failed attempts are only not counted.
    if (st == ST_OK && good_count < 3) begin
      good_dist[good_count] = q;
      good_count++;
    end
    if (attempt_no < ATTEMPTS) attempt_no++;
    if (cfg_gap == 0) begin
      close_gap();
    end else begin
      ph = PH_GAP;
      phase_ticks = '0;
    end
  endfunction

  function automatic ucr_res_t ranger_tick(input logic start, input logic level);
    int unsigned lo_lim;
    int unsigned hi_lim;
    int unsigned dist_q;
    tick_out = '0;
    if (ph == PH_IDLE && start) begin
      ph = PH_LOW;
      phase_ticks = '0;
      attempt_no = '0;
      good_count = '0;
    end
    case (ph)
      PH_LOW: begin
        phase_ticks++;
        if (phase_ticks >= TRIG_LOW_TICKS) begin
          ph = PH_HIGH;
          phase_ticks = '0;
        end
      end
      PH_HIGH: begin
        tick_out.trig = 1'b1;
        phase_ticks++;
        if (phase_ticks >= TRIG_HIGH_TICKS) begin
          ph = PH_RISE;
          phase_ticks = '0;
        end
      end
      PH_RISE: begin
        if (level) begin
          ph = PH_FALL;
          phase_ticks = '0;
          pulse_width = 16'd1;
        end else if (phase_ticks >= cfg_timeout) begin
          end_attempt(ST_TIMEOUT, '0);
        end else begin
          phase_ticks++;
        end
      end
      PH_FALL: begin
        if (!level) begin
          lo_lim = cfg_min_cm * TICKS_PER_CM;
          hi_lim = cfg_max_cm * TICKS_PER_CM;
          if (pulse_width < lo_lim || pulse_width > hi_lim) begin
            end_attempt(ST_RANGE, '0);
          end else begin
            dist_q = 32'(pulse_width);
            dist_q = (dist_q << FRACTION_BITS) / TICKS_PER_CM;
            if (dist_q > Q_MAX) dist_q = Q_MAX;
            end_attempt(ST_OK, dist_q[DIST_W-1:0]);
          end
        end else if (phase_ticks >= cfg_timeout) begin
          end_attempt(ST_TIMEOUT, '0);
        end else begin
          phase_ticks++;
          if (pulse_width != WIDTH_MAX) pulse_width++;
        end
      end
      PH_GAP: begin
        phase_ticks++;
        if (phase_ticks >= cfg_gap) close_gap();
      end
      default: ;
    endcase
    tick_out.busy_res = (ph != PH_IDLE);
    return tick_out;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one tick item, with an occasional idle burst ahead of it, and log its
  // expected result. Return at the edge where the item is taken.
  task automatic send_tick(input logic start, input logic level);
    if (bursts_on && $urandom_range(15) == 0) begin
      tick.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    tick.valid <= 1'b1;
    tick.op    <= start;
    tick.echo  <= level;
    tick_results_due.push_back(ranger_tick(start, level));
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
  endtask

  // Stop feeding ticks and hold until every result is back, so the block is idle.
  task automatic settle_ranger();
    tick.valid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic poke(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  // Write all five registers while idle; stuff junk above the mode bit and the centimeter fields.
  task automatic apply_config(input logic mode, input logic [9:0] lo_cm,
                              input logic [9:0] hi_cm, input logic [TW-1:0] tmo,
                              input logic [TW-1:0] gap_len);
    logic [CFG_DW-1:0] junk;
    settle_ranger();
    junk = CFG_DW'($urandom);
    poke(REG_MEDIAN_MODE, {junk[15:1], mode});
    poke(REG_MIN_CM, {junk[5:0], lo_cm});
    junk = CFG_DW'($urandom);
    poke(REG_MAX_CM, {junk[15:10], hi_cm});
    poke(REG_ECHO_TMO, tmo);
    poke(REG_GAP, gap_len);
    wr_en <= 1'b0;
    @(posedge clk);
    cfg_median  = mode;
    cfg_min_cm  = lo_cm;
    cfg_max_cm  = hi_cm;
    cfg_timeout = tmo;
    cfg_gap     = gap_len;
  endtask

  // Start one measurement and shape the echo from the sequence's own phase until
  // it ends. rise_at is the number of low ticks before the echo rises; p0..p2 the
  // echo-high length of each attempt. A negative value draws a fresh one per
  // attempt. noise_pct flips that share of echo samples.
  task automatic run_measurement(input int rise_at, input int p0, input int p1,
                                 input int p2, input int noise_pct);
    int          pick;
    int          lo_lim;
    int          hi_lim;
    int unsigned rise_wait;
    int unsigned pulse_ticks;
    int unsigned low_seen;
    int unsigned high_seen;
    logic        level;
    rise_wait = 0;
    pulse_ticks = 1;
    low_seen = 0;
    high_seen = 0;
    repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(1)));
    send_tick(1'b1, 1'($urandom_range(1)));
    while (ph != PH_IDLE) begin
      case (ph)
        PH_RISE: begin
          level = (low_seen >= rise_wait);
          low_seen++;
        end
        PH_FALL: begin
          // The rise tick already counts as one tick of width.
          high_seen++;
          level = (high_seen < pulse_ticks);
        end
        default: begin
          // Plan the next attempt's echo; the last draw before the wait wins.
          if (rise_at >= 0) begin
            rise_wait = rise_at;
          end else begin
            case ($urandom_range(7))
              0: rise_wait = 32'(cfg_timeout);
              1: rise_wait = cfg_timeout + 1;
              default: rise_wait = $urandom_range(0, (cfg_timeout < 40) ? cfg_timeout : 40);
            endcase
          end
          case (attempt_no)
            2'd0:    pick = p0;
            2'd1:    pick = p1;
            default: pick = p2;
          endcase
          if (pick < 0) begin
            lo_lim = cfg_min_cm * 58;
            hi_lim = cfg_max_cm * 58;
            case ($urandom_range(9))
              0: pick = lo_lim;
              1: pick = lo_lim - 1;
              2: pick = hi_lim;
              3: pick = hi_lim + 1;
              4: pick = cfg_timeout + 1;
              5: pick = cfg_timeout + 2;
              6: pick = $urandom_range(1, 8);
              default: pick = (lo_lim <= hi_lim) ? $urandom_range(lo_lim, hi_lim)
                                                 : $urandom_range(1, 300);
            endcase
          end
          pulse_ticks = (pick < 1) ? 1 : pick;
          low_seen = 0;
          high_seen = 0;
          level = 1'($urandom_range(1));
        end
      endcase
      if ($urandom_range(99) < noise_pct) level = ~level;
      // A start request while busy must be ignored.
      send_tick($urandom_range(7) == 0, level);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: single mode, 2..400 cm, long timeouts.
  task automatic test_defaults();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    run_measurement(0, 116, -1, -1, 0);    // exactly the lower limit
  endtask

  // Edge waits and range limits in single mode, plus writes that must be dropped.
  task automatic test_single_boundaries();
    logic [CFG_DW-1:0] junk;
    apply_config(1'b0, 10'd0, 10'd1, 16'd4, 16'd0);
    junk = CFG_DW'($urandom);
    poke(REG_SPARE_LO, junk);
    poke(REG_SPARE_HI, ~junk);
    wr_en <= 1'b0;
    @(posedge clk);
    run_measurement(4, 3, -1, -1, 0);      // rise on the last allowed tick
    run_measurement(5, 3, -1, -1, 0);      // rise wait times out
    run_measurement(0, 5, -1, -1, 0);      // fall on the last allowed tick
    run_measurement(0, 6, -1, -1, 0);      // fall wait times out
    // Inverted limits reject every echo.
    apply_config(1'b0, 10'd1023, 10'd0, 16'd4, 16'd0);
    run_measurement(0, 1, -1, -1, 0);
    // Equal limits: a width of exactly one centimeter is in range at both ends.
    apply_config(1'b0, 10'd1, 10'd1, 16'd60, 16'd0);
    run_measurement(0, 58, -1, -1, 0);
  endtask

  // Three attempts per start: median, first success, or timeout when none succeed.
  task automatic test_median_voting();
    apply_config(1'b1, 10'd0, 10'd1, 16'd12, 16'd1);
    run_measurement(0, 8, 4, 11, 0);       // three successes
    run_measurement(0, 4, 14, 8, 0);       // one fall timeout between two good
    apply_config(1'b1, 10'd0, 10'd1, 16'd12, 16'd0);
    run_measurement(1, 11, 8, 4, 0);       // no pause between attempts
  endtask

  // Widest register values accepted and held at full width.
  task automatic test_register_extremes();
    apply_config(1'b0, 10'd0, 10'd1023, 16'hFFFF, 16'hFFFF);
    run_measurement(3, 20, -1, -1, 0);
  endtask

  // Random settings kept small, each with a batch of mostly clean measurements.
  task automatic test_random_ranging(input int settings, input int per_setting);
    logic [TW-1:0] tmo;
    logic [TW-1:0] gap_len;
    int            noise;
    for (int s = 0; s < settings; s++) begin
      case ($urandom_range(3))
        0:       tmo = 16'd1;
        1:       tmo = 16'($urandom_range(2, 6));
        default: tmo = 16'($urandom_range(7, 12));
      endcase
      case ($urandom_range(3))
        0:       gap_len = 16'd0;
        1:       gap_len = 16'd1;
        default: gap_len = 16'($urandom_range(2, 4));
      endcase
      apply_config(1'($urandom_range(1)), ($urandom_range(3) == 0) ? 10'd1 : 10'd0,
                   10'($urandom_range(0, 3)), tmo, gap_len);
      for (int k = 0; k < per_setting; k++) begin
        case ($urandom_range(9))
          0:       noise = 3;
          1:       noise = 25;
          default: noise = 0;
        endcase
        run_measurement(-1, -1, -1, -1, noise);
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : take_results
    ucr_res_t    due;
    int unsigned stall_left;
    if (rst) begin
      result.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (tick_results_due.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          mismatches++;
        end else begin
          due = tick_results_due.pop_front();
          check_field("trig", 32'(due.trig), 32'(result.trig));
          check_field("busy_res", 32'(due.busy_res), 32'(result.busy_res));
          check_field("done_res", 32'(due.done_res), 32'(result.done_res));
          check_field("status", 32'(due.status), 32'(result.status));
          check_field("distance_q4", 32'(due.distance_q4), 32'(result.distance_q4));
        end
      end
      // Hold ready low in bursts now and then.
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(15) == 0) begin
        stall_left = $urandom_range(0, 12);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run with errors once the cycle limit is reached.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    good_dist[0] = '0;
    good_dist[1] = '0;
    good_dist[2] = '0;
    rst          <= 1'b1;
    wr_en        <= 1'b0;
    wr_index     <= REG_MEDIAN_MODE;
    wr_data      <= '0;
    tick.valid   <= 1'b0;
    tick.op      <= 1'b0;
    tick.echo    <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_single_boundaries();
    test_median_voting();
    test_register_extremes();
    test_random_ranging(2, 1);
    // Close with a stretch that has no idle bursts on either side.
    bursts_on = 1'b0;
    test_random_ranging(1, 2);

    // Drain, then keep watching for any stray result before the verdict.
    settle_ranger();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
